>>> sv/smh_pkg.sv
// smh_pkg: shared types, constants and SHA-256 helper functions for the message hasher.
// Used by smh_msg_sched, smh_round and sha256_message_hasher; depends on nothing.
`default_nettype none

package smh_pkg;

	typedef logic [31:0] word_t;
	// Eight words, index 0 is word a / H0
	typedef word_t [0:7] wvars_t;

	localparam int COUNT_W = 61;

	localparam logic [5:0] LAST_POS      = 6'd63;
	localparam logic [5:0] LEN_POS       = 6'd56;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;
	localparam logic [7:0] PAD_BYTE      = 8'h80;

	localparam wvars_t HASH_IV = {
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_LEN,
		ST_EMIT
	} state_t;

	// Commands from the sequencer to the block buffer
	typedef struct packed {
		logic        put_byte;
		logic [7:0]  byte_val;
		logic [5:0]  pos;
		logic        clear_after;
		logic        clear_all;
		logic        put_len;
		logic [63:0] bit_len;
		logic        shift;
	} blk_ctrl_t;

	function automatic word_t big_sigma0(word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

>>> sv/smh_if.sv
// smh_msg_if and smh_digest_if: valid/ready channels of the message hasher.
// No dependencies.
`default_nettype none

interface smh_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface smh_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

>>> sv/smh_round.sv
// smh_round: one SHA-256 compression round, shared over all 64 rounds.
// Depends on smh_pkg.
`default_nettype none

module smh_round (
	input  smh_pkg::wvars_t wv,
	input  smh_pkg::word_t  k,
	input  smh_pkg::word_t  w,
	output smh_pkg::wvars_t wv_next
);
	import smh_pkg::*;

	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	// Choice and majority
	assign ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
	assign maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);

	assign t1 = wv[7] + big_sigma1(wv[4]) + ch + k + w;
	assign t2 = big_sigma0(wv[0]) + maj;

	// a..h shift down by one
	assign wv_next = {t1 + t2, wv[0], wv[1], wv[2], wv[3] + t1, wv[4], wv[5], wv[6]};

endmodule

`default_nettype wire

>>> sv/smh_msg_sched.sv
// smh_msg_sched: 16-word block buffer that is filled byte by byte and padded,
// then slides as the message schedule window during compression. Depends on smh_pkg.
`default_nettype none

module smh_msg_sched (
	input  logic                clk,
	input  smh_pkg::blk_ctrl_t  ctrl,
	output smh_pkg::word_t      w_cur
);
	import smh_pkg::*;

	word_t      blk_q [16];
	word_t      blk_d [16];
	word_t      w_new;
	word_t      byte_word;
	logic [4:0] sh;
	logic [3:0] idx;

	// Next schedule word from the window taps
	assign w_new = blk_q[0] + small_sigma0(blk_q[1]) + blk_q[9] + small_sigma1(blk_q[14]);
	assign w_cur = blk_q[0];

	// Byte lane placement, big-endian within a word
	assign idx       = ctrl.pos[5:2];
	assign sh        = {~ctrl.pos[1:0], 3'b000};
	assign byte_word = word_t'(ctrl.byte_val) << sh;

	// Buffer update: slide during rounds, otherwise byte, pad and length writes
	always_comb begin
		if (ctrl.shift) begin
			for (int i = 0; i < 15; i++) begin
				blk_d[i] = blk_q[i + 1];
			end
			blk_d[15] = w_new;
		end else begin
			for (int i = 0; i < 16; i++) begin
				blk_d[i] = blk_q[i];
				if (ctrl.clear_all || (ctrl.clear_after && (4'(i) > idx))) begin
					blk_d[i] = '0;
				end
				if (ctrl.put_byte && (4'(i) == idx)) begin
					// first byte of a word clears the rest of it
					blk_d[i] = ((ctrl.pos[1:0] == 2'd0) ? '0 : blk_q[i]) | byte_word;
				end
			end
			if (ctrl.put_len) begin
				blk_d[14] = ctrl.bit_len[63:32];
				blk_d[15] = ctrl.bit_len[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		blk_q <= blk_d;
	end

endmodule

`default_nettype wire

>>> sv/sha256_message_hasher.sv
// sha256_message_hasher: top level; sequencer, byte counter, hash and working registers.
// Depends on smh_pkg, smh_if, smh_round and smh_msg_sched.
//
//   channel   dir   payload                                 transfer when
//   message   in    data_byte, has_byte, end_of_message     valid & ready
//   digest    out   digest_word, word_index, last_word      valid & ready
//
// A byte that does not complete a 64-byte block is taken while the hasher stays idle.
// A completed block runs 64 rounds of the single shared round unit, then ST_FINAL for
// the hash add. An end item adds the ST_PAD state and one compression (two, plus the
// ST_LEN state, when the tail holds 56 or more bytes), then eight digest transfers.
// message.ready is high only while idle; digest stalls hold the sequencer in place.
// arst_n resets the hash to the initial values and the byte count to zero.
`default_nettype none

module sha256_message_hasher (
	input  logic          clk,
	input  logic          arst_n,
	smh_msg_if.sink       message,
	smh_digest_if.source  digest
);
	import smh_pkg::*;

	state_t               state_q;
	state_t               state_d;
	state_t               ret_q;
	state_t               ret_d;
	logic [5:0]           rnd_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [2:0]           widx_q;
	wvars_t               hash_q;
	wvars_t               wv_q;
	wvars_t               wv_rnd;
	word_t                w_cur;
	blk_ctrl_t            blk_ctrl;
	logic                 in_xfer;
	logic                 out_xfer;
	logic                 start_cmp;

	assign in_xfer   = message.valid & message.ready;
	assign out_xfer  = digest.valid & digest.ready;
	assign start_cmp = (state_d == ST_ROUND) && (state_q != ST_ROUND);

	smh_round u_round (
		.wv      (wv_q),
		.k       (ROUND_K[rnd_q]),
		.w       (w_cur),
		.wv_next (wv_rnd)
	);

	smh_msg_sched u_sched (
		.clk   (clk),
		.ctrl  (blk_ctrl),
		.w_cur (w_cur)
	);

	// Next state and return state after a compression
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (message.has_byte && (cnt_q[5:0] == LAST_POS)) begin
						state_d = ST_ROUND;
						ret_d   = message.end_of_message ? ST_PAD : ST_IDLE;
					end else if (message.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				state_d = ret_q;
			end
			ST_PAD: begin
				state_d = ST_ROUND;
				ret_d   = (cnt_q[5:0] >= LEN_POS) ? ST_LEN : ST_EMIT;
			end
			ST_LEN: begin
				state_d = ST_ROUND;
				ret_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_xfer && (widx_q == LAST_WORD_IDX)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshakes and buffer commands
	always_comb begin
		message.ready        = (state_q == ST_IDLE);
		digest.valid         = (state_q == ST_EMIT);
		blk_ctrl.put_byte    = 1'b0;
		blk_ctrl.byte_val    = message.data_byte;
		blk_ctrl.pos         = cnt_q[5:0];
		blk_ctrl.clear_after = 1'b0;
		blk_ctrl.clear_all   = 1'b0;
		blk_ctrl.put_len     = 1'b0;
		blk_ctrl.bit_len     = {cnt_q, 3'b000};
		blk_ctrl.shift       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				blk_ctrl.put_byte = in_xfer & message.has_byte;
			end
			ST_ROUND: begin
				blk_ctrl.shift = 1'b1;
			end
			ST_PAD: begin
				blk_ctrl.put_byte    = 1'b1;
				blk_ctrl.byte_val    = PAD_BYTE;
				blk_ctrl.clear_after = 1'b1;
				blk_ctrl.put_len     = (cnt_q[5:0] < LEN_POS);
			end
			ST_LEN: begin
				blk_ctrl.clear_all = 1'b1;
				blk_ctrl.put_len   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign digest.digest_word = hash_q[0];
	assign digest.word_index  = widx_q;
	assign digest.last_word   = (widx_q == LAST_WORD_IDX);

	// Control state, counter and hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= '0;
			cnt_q   <= '0;
			widx_q  <= '0;
			hash_q  <= HASH_IV;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (start_cmp) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (in_xfer && message.has_byte) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
			if (state_q == ST_FINAL) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + wv_q[i];
				end
			end else if (out_xfer) begin
				if (widx_q == LAST_WORD_IDX) begin
					hash_q <= HASH_IV;
					cnt_q  <= '0;
					widx_q <= '0;
				end else begin
					// rotate so the next word sits at the output
					hash_q <= {hash_q[1:7], hash_q[0]};
					widx_q <= widx_q + 3'd1;
				end
			end
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (start_cmp) begin
			wv_q <= hash_q;
		end else if (state_q == ST_ROUND) begin
			wv_q <= wv_rnd;
		end
	end

endmodule

`default_nettype wire

>>> sv/smh_checker.sv
// smh_checker: port-level assertions for sha256_message_hasher, and its bind.
// No package dependency.
`default_nettype none

module smh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_end,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_index,
	input logic       out_last
);

	// Input side is closed while digest words are offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while digest valid");

	// Digest words come in order without a gap in valid
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_last) |=>
		(out_valid && (out_index == $past(out_index) + 3'd1)))
		else $error("digest word index did not advance");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_index == 3'd7)))
		else $error("last_word mismatch");

	// Back to idle right after the final word
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> in_ready)
		else $error("not ready after digest");

	// End of message starts padding or a block compression, so input closes
	a_busy_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_end) |=> !in_ready)
		else $error("ready right after end of message");

endmodule

bind sha256_message_hasher smh_checker u_smh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (message.valid),
	.in_ready  (message.ready),
	.in_end    (message.end_of_message),
	.out_valid (digest.valid),
	.out_ready (digest.ready),
	.out_index (digest.word_index),
	.out_last  (digest.last_word)
);

`default_nettype wire

>>> tb/sv/sha256_digest_checker.sv
// sha256_digest_checker: watches both channels of sha256_message_hasher, predicts the digest
// of every finished message and compares each digest transfer field by field.
// Depends on smh_pkg (word_t) and the channel interfaces in smh_if.
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	smh_msg_if          message,
	smh_digest_if       digest,
	output int unsigned mismatch_count,
	output int unsigned words_pending
);
	import smh_pkg::*;

	typedef struct packed {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} digest_entry_t;

	localparam word_t CHAIN_IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam word_t ROUND_CONST [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	// Predicted hasher state
	word_t         chain_value [8];
	word_t         block_buf [16];
	logic [60:0]   msg_bytes;
	digest_entry_t expected_digest [$];

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of block_buf into chain_value
	function automatic void compress_block();
		word_t sched [64];
		word_t v [8];
		word_t t1, t2;
		for (int i = 0; i < 16; i++)
			sched[i] = block_buf[i];
		for (int i = 16; i < 64; i++)
			sched[i] = sched[i-16] + sched[i-7]
				+ (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
				+ (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
		for (int i = 0; i < 8; i++)
			v[i] = chain_value[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + sched[r];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_value[i] += v[i];
	endfunction

	// Big-endian byte placement; the first byte of a word overwrites it
	function automatic void place_byte(logic [5:0] pos, logic [7:0] b);
		word_t lane;
		lane = word_t'(b) << (24 - 8 * pos[1:0]);
		if (pos[1:0] == 2'd0)
			block_buf[pos[5:2]] = lane;
		else
			block_buf[pos[5:2]] |= lane;
	endfunction

	function automatic void restart_message();
		for (int i = 0; i < 8; i++)
			chain_value[i] = CHAIN_IV[i];
		msg_bytes = '0;
	endfunction

	// Absorb one message item; an end item pads, finishes and queues eight digest words
	function automatic void hash_item(logic [7:0] b, logic hb, logic eom);
		logic [5:0]    pos;
		logic [63:0]   bit_len;
		digest_entry_t entry;
		if (hb) begin
			pos = msg_bytes[5:0];
			place_byte(pos, b);
			msg_bytes = msg_bytes + 61'd1;
			if (pos == 6'd63)
				compress_block();
		end
		if (eom) begin
			pos = msg_bytes[5:0];
			place_byte(pos, 8'h80);
			for (int i = pos[5:2] + 1; i < 16; i++)
				block_buf[i] = '0;
			// no room left for the length: spill into a second tail block
			if (pos >= 6'd56) begin
				compress_block();
				for (int i = 0; i < 16; i++)
					block_buf[i] = '0;
			end
			bit_len = {msg_bytes, 3'b000};
			block_buf[14] = bit_len[63:32];
			block_buf[15] = bit_len[31:0];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				entry = '{digest_word: chain_value[i], word_index: 3'(i),
					last_word: (i == 7)};
				expected_digest = {expected_digest, entry};
			end
			restart_message();
		end
	endfunction

	// Compare digest transfers, then fold in message transfers
	always @(posedge clk or negedge arst_n) begin
		digest_entry_t head;
		if (!arst_n) begin
			restart_message();
			for (int i = 0; i < 16; i++)
				block_buf[i] = '0;
			expected_digest.delete();
			mismatch_count = 0;
			words_pending = 0;
		end else begin
			if (digest.valid && digest.ready) begin
				if (expected_digest.size() == 0) begin
					$error("unexpected digest transfer: digest_word %h word_index %0d",
						digest.digest_word, digest.word_index);
					mismatch_count++;
				end else begin
					head = expected_digest.pop_front();
					if (digest.digest_word !== head.digest_word) begin
						$error("digest_word: expected %h, actual %h",
							head.digest_word, digest.digest_word);
						mismatch_count++;
					end
					if (digest.word_index !== head.word_index) begin
						$error("word_index: expected %0d, actual %0d",
							head.word_index, digest.word_index);
						mismatch_count++;
					end
					if (digest.last_word !== head.last_word) begin
						$error("last_word: expected %0b, actual %0b",
							head.last_word, digest.last_word);
						mismatch_count++;
					end
				end
			end
			if (message.valid && message.ready)
				hash_item(message.data_byte, message.has_byte, message.end_of_message);
			words_pending = expected_digest.size();
		end
	end

endmodule

>>> tb/sv/sha256_message_hasher_tb.sv
// sha256_message_hasher_tb: clock, reset and message stimulus for sha256_message_hasher,
// random digest back-pressure, and the verdict. Depends on smh_if, the block and
// sha256_digest_checker.
module sha256_message_hasher_tb;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 150;
	localparam int unsigned HOLD_AFTER   = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned mismatch_count;
	int unsigned words_pending;
	int unsigned cycle_count;
	int          tx_burst = 0;
	int          rx_burst = 0;

	smh_msg_if    msg_ch ();
	smh_digest_if dig_ch ();

	sha256_message_hasher DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.message(msg_ch),
		.digest (dig_ch)
	);

	sha256_digest_checker u_digest_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.message       (msg_ch),
		.digest        (dig_ch),
		.mismatch_count(mismatch_count),
		.words_pending (words_pending)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Idle length: mostly none or short, a few long, with occasional gap-free bursts
	function automatic int idle_len(inout int burst_left);
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(99);
		if (roll < 8) begin
			burst_left = $urandom_range(30, 10);
			return 0;
		end
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// One message-channel transfer, after a random idle stretch
	task automatic push_item(input logic [7:0] b, input logic hb, input logic eom);
		int gap;
		gap = idle_len(tx_burst);
		repeat (gap) begin
			@(negedge clk);
			msg_ch.valid <= 1'b0;
		end
		@(negedge clk);
		msg_ch.valid          <= 1'b1;
		msg_ch.data_byte      <= b;
		msg_ch.has_byte       <= hb;
		msg_ch.end_of_message <= eom;
		do @(posedge clk); while (!msg_ch.ready);
	endtask

	// Random message body with stray ignored items; ends on the last byte or on a bare end
	task automatic send_message(input int len, input bit bare_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				push_item(8'($urandom), 1'b0, 1'b0);
			push_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
		end
		if (bare_end || len == 0)
			push_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Message stimulus and verdict
	initial begin
		int  msg_num;
		int  item_total;
		int  len;
		bit  bare;
		msg_ch.valid          = 1'b0;
		msg_ch.data_byte      = '0;
		msg_ch.has_byte       = 1'b0;
		msg_ch.end_of_message = 1'b0;
		wait (arst_n);

		// empty message
		push_item(8'h00, 1'b0, 1'b1);
		// ignored byte, extreme bytes, last byte carries the end
		push_item(8'hFF, 1'b0, 1'b0);
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0);
		push_item(8'hA5, 1'b1, 1'b1);
		// "abc" closed by a bare end
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'h63, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
		// bare end with junk data after an ignored item
		push_item(8'h12, 1'b1, 1'b0);
		push_item(8'h5A, 1'b0, 1'b0);
		push_item(8'hC3, 1'b0, 1'b1);

		// random messages; the first spills into two tail blocks, the second
		// completes a full block before its tail
		msg_num = 0;
		item_total = 12;
		while (item_total < 100 || msg_num < 2) begin
			if (msg_num == 0)
				len = $urandom_range(63, 56);
			else if (msg_num == 1)
				len = $urandom_range(67, 64);
			else
				len = $urandom_range(12, 0);
			bare = (len == 0) || ($urandom_range(1) == 1);
			send_message(len, bare);
			item_total += len + (bare ? 1 : 0);
			msg_num++;
		end
		@(negedge clk);
		msg_ch.valid <= 1'b0;

		while (words_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && words_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Digest receiver: random stalls, plus one long hold-off once a digest is waiting
	initial begin
		int unsigned taken;
		bit          held;
		int          gap;
		taken = 0;
		held = 1'b0;
		dig_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			gap = idle_len(rx_burst);
			if (taken == HOLD_AFTER && !held) begin
				held = 1'b1;
				@(negedge clk);
				dig_ch.ready <= 1'b0;
				while (!dig_ch.valid) @(negedge clk);
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				repeat (gap) begin
					@(negedge clk);
					dig_ch.ready <= 1'b0;
				end
			end
			@(negedge clk);
			dig_ch.ready <= 1'b1;
			do @(posedge clk); while (!dig_ch.valid);
			taken++;
		end
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule
